@@ design/lirenc_pkg.sv @@
// Shared constants and types for the literal/increment run encoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package lirenc_pkg;

  // Count cap for both nibbles of a chunk header.
  localparam int MAX_COUNT = 15;
  localparam int CNT_W     = 4;
  localparam int LC_W      = 5;

  // Literal FIFO: deep enough for one full open chunk plus queued chunks.
  localparam int LIT_DEPTH = 32;
  localparam int LIT_AW    = $clog2(LIT_DEPTH);
  localparam int LIT_CNT_W = LIT_AW + 1;

  // Chunk command FIFO between front and back.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = CMD_AW + 1;

  // Micro-operations produced by the front for one accepted byte.
  localparam int OP_DEPTH  = 4;
  localparam int OP_AW     = $clog2(OP_DEPTH);
  localparam int OP_CNT_W  = OP_AW + 1;

  typedef enum logic [1:0] {
    OP_PUSH = 2'b01,
    OP_CMD  = 2'b10
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic        last;
  } op_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
  } lit_push_t;

  typedef struct packed {
    logic [7:0]  hdr;
    logic        last;
  } chunk_cmd_t;

  typedef struct packed {
    logic        lit_full;
    logic        cmd_full;
  } q_status_t;

endpackage

@@ design/literal_increment_run_encoder_unit.sv @@
// Literal/increment run encoder. A new byte is accepted only once every literal
// write and chunk command that the front planned for the previous byte has been
// issued to the queues. Each chunk goes out as its header byte followed by its
// literals, which are read from the literal FIFO. Reset clears step_size, the
// chunk state and both queues; the literal RAM is not cleared.
module literal_increment_run_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,   // step_size
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] data_byte
  input  logic       in_tlast,      // final_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast      // out_last
);
  import lirenc_pkg::*;

  lit_push_t  push;
  logic       cmd_valid;
  chunk_cmd_t cmd_in;
  q_status_t  q_status;
  logic       cmd_empty;
  chunk_cmd_t cmd_head;
  logic       cmd_pop;
  logic       lit_pop;
  logic [7:0] lit_data;

  lirenc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_data     (in_tdata),
    .in_final    (in_tlast),
    .push_o      (push),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in),
    .q_status_i  (q_status)
  );

  lirenc_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_in),
    .status_o    (q_status),
    .cmd_empty_o (cmd_empty),
    .cmd_head_o  (cmd_head),
    .cmd_pop_i   (cmd_pop),
    .lit_pop_i   (lit_pop),
    .lit_data_o  (lit_data)
  );

  lirenc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .lit_pop_o   (lit_pop),
    .lit_data_i  (lit_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

@@ design/lirenc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the literal FIFO storage.
module lirenc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/lirenc_front.sv @@
// Front end: takes source bytes, tracks the open chunk and emits literal
// writes and chunk commands one per cycle while their queue is not full. Depends on lirenc_pkg.
module lirenc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_data,
  input  logic                   in_final,
  output lirenc_pkg::lit_push_t  push_o,
  output logic                   cmd_valid_o,
  output lirenc_pkg::chunk_cmd_t cmd_o,
  input  lirenc_pkg::q_status_t  q_status_i
);
  import lirenc_pkg::*;

  logic [7:0]          step_r;
  logic [7:0]          rv_r, rv_nxt;
  logic [LC_W-1:0]     lc_r, lc_nxt;
  logic [CNT_W-1:0]    ic_r, ic_nxt;
  op_t                 op_r [OP_DEPTH];
  logic [OP_CNT_W-1:0] op_cnt_r;

  op_t                 plan [OP_DEPTH];
  logic [OP_CNT_W-1:0] plan_cnt;
  logic [OP_AW-1:0]    last_idx;
  logic                has_cmd;
  logic [7:0]          pred;
  logic [CNT_W-1:0]    ic_inc;
  logic [LC_W-1:0]     lc_a, lc_b, lc_c;
  logic [CNT_W-1:0]    ic_c;
  logic                accept;
  logic                can_issue;
  op_t                 head;

  function automatic op_t mk_push(input logic [7:0] b);
    op_t o;
    o.kind = OP_PUSH;
    o.data = b;
    o.last = 1'b0;
    return o;
  endfunction

  function automatic op_t mk_cmd(input logic [CNT_W-1:0] lits, input logic [CNT_W-1:0] incs);
    op_t o;
    o.kind = OP_CMD;
    o.data = {incs, lits};
    o.last = 1'b0;
    return o;
  endfunction

  // Work out the whole effect of one byte: the new chunk state and the
  // ordered list of literal writes and chunk commands it causes.
  always_comb begin
    pred     = rv_r + step_r;
    ic_inc   = ic_r + CNT_W'(1);
    plan_cnt = '0;
    last_idx = '0;
    has_cmd  = 1'b0;
    lc_a     = lc_r;
    lc_b     = lc_r;
    lc_c     = lc_r;
    ic_c     = ic_r;
    for (int i = 0; i < OP_DEPTH; i++) begin
      plan[i] = mk_push(8'h00);
    end

    if (in_data == pred) begin
      if (ic_inc >= CNT_W'(MAX_COUNT)) begin
        plan[plan_cnt[OP_AW-1:0]] = mk_cmd(lc_r[CNT_W-1:0], ic_inc);
        last_idx = plan_cnt[OP_AW-1:0];
        has_cmd  = 1'b1;
        plan_cnt = plan_cnt + OP_CNT_W'(1);
        lc_c     = '0;
        ic_c     = '0;
      end else begin
        ic_c = ic_inc;
      end
    end else begin
      if (ic_r > CNT_W'(1)) begin
        plan[plan_cnt[OP_AW-1:0]] = mk_cmd(lc_r[CNT_W-1:0], ic_r);
        last_idx = plan_cnt[OP_AW-1:0];
        has_cmd  = 1'b1;
        plan_cnt = plan_cnt + OP_CNT_W'(1);
        lc_a     = '0;
      end else if (ic_r == CNT_W'(1)) begin
        // A lone increment turns into a literal.
        plan[plan_cnt[OP_AW-1:0]] = mk_push(rv_r);
        plan_cnt = plan_cnt + OP_CNT_W'(1);
        lc_a     = lc_r + LC_W'(1);
      end
      plan[plan_cnt[OP_AW-1:0]] = mk_push(in_data);
      plan_cnt = plan_cnt + OP_CNT_W'(1);
      lc_b     = lc_a + LC_W'(1);
      ic_c     = '0;
      if (lc_b >= LC_W'(MAX_COUNT)) begin
        // A full chunk; a sixteenth literal carries over to the next one.
        plan[plan_cnt[OP_AW-1:0]] = mk_cmd(CNT_W'(MAX_COUNT), '0);
        last_idx = plan_cnt[OP_AW-1:0];
        has_cmd  = 1'b1;
        plan_cnt = plan_cnt + OP_CNT_W'(1);
        lc_c     = lc_b - LC_W'(MAX_COUNT);
      end else begin
        lc_c = lc_b;
      end
    end

    if (in_final && (lc_c != '0 || ic_c != '0)) begin
      plan[plan_cnt[OP_AW-1:0]] = mk_cmd(lc_c[CNT_W-1:0], ic_c);
      last_idx = plan_cnt[OP_AW-1:0];
      has_cmd  = 1'b1;
      plan_cnt = plan_cnt + OP_CNT_W'(1);
    end

    if (has_cmd) begin
      plan[last_idx].last = 1'b1;
    end

    if (in_final) begin
      rv_nxt = '0;
      lc_nxt = '0;
      ic_nxt = '0;
    end else begin
      rv_nxt = in_data;
      lc_nxt = lc_c;
      ic_nxt = ic_c;
    end
  end

  assign head     = op_r[0];
  assign in_ready = (op_cnt_r == '0);
  assign accept   = in_valid && in_ready;

  always_comb begin
    can_issue = 1'b0;
    if (op_cnt_r != '0) begin
      unique case (head.kind)
        OP_PUSH: can_issue = !q_status_i.lit_full;
        OP_CMD:  can_issue = !q_status_i.cmd_full;
        default: can_issue = 1'b0;
      endcase
    end
  end

  assign push_o.valid = can_issue && (head.kind == OP_PUSH);
  assign push_o.data  = head.data;
  assign cmd_valid_o  = can_issue && (head.kind == OP_CMD);
  assign cmd_o.hdr    = head.data;
  assign cmd_o.last   = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      rv_r     <= '0;
      lc_r     <= '0;
      ic_r     <= '0;
      op_cnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      if (accept) begin
        rv_r     <= rv_nxt;
        lc_r     <= lc_nxt;
        ic_r     <= ic_nxt;
        op_cnt_r <= plan_cnt;
      end else if (can_issue) begin
        op_cnt_r <= op_cnt_r - OP_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < OP_DEPTH; i++) begin
        op_r[i] <= plan[i];
      end
    end else if (can_issue) begin
      for (int i = 0; i < OP_DEPTH - 1; i++) begin
        op_r[i] <= op_r[i + 1];
      end
    end
  end

endmodule

@@ design/lirenc_queue.sv @@
// Queues between front and back: a small chunk command FIFO in flops and
// a literal FIFO held in lirenc_ram. Depends on lirenc_pkg and lirenc_ram.
module lirenc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lirenc_pkg::lit_push_t  push_i,
  input  logic                   cmd_valid_i,
  input  lirenc_pkg::chunk_cmd_t cmd_i,
  output lirenc_pkg::q_status_t  status_o,
  output logic                   cmd_empty_o,
  output lirenc_pkg::chunk_cmd_t cmd_head_o,
  input  logic                   cmd_pop_i,
  input  logic                   lit_pop_i,
  output logic [7:0]             lit_data_o
);
  import lirenc_pkg::*;

  chunk_cmd_t           cmd_mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0]    cmd_wp_r, cmd_rp_r;
  logic [CMD_CNT_W-1:0] cmd_cnt_r;
  logic [LIT_AW-1:0]    lit_wp_r, lit_rp_r;
  logic [LIT_CNT_W-1:0] lit_cnt_r;

  assign status_o.cmd_full = (cmd_cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign status_o.lit_full = (lit_cnt_r == LIT_CNT_W'(LIT_DEPTH));
  assign cmd_empty_o       = (cmd_cnt_r == '0);
  assign cmd_head_o        = cmd_mem_r[cmd_rp_r];

  always_ff @(posedge clk) begin
    if (cmd_valid_i) begin
      cmd_mem_r[cmd_wp_r] <= cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_wp_r  <= '0;
      cmd_rp_r  <= '0;
      cmd_cnt_r <= '0;
      lit_wp_r  <= '0;
      lit_rp_r  <= '0;
      lit_cnt_r <= '0;
    end else begin
      if (cmd_valid_i) begin
        cmd_wp_r <= cmd_wp_r + CMD_AW'(1);
      end
      if (cmd_pop_i) begin
        cmd_rp_r <= cmd_rp_r + CMD_AW'(1);
      end
      cmd_cnt_r <= cmd_cnt_r + CMD_CNT_W'(cmd_valid_i) - CMD_CNT_W'(cmd_pop_i);
      if (push_i.valid) begin
        lit_wp_r <= lit_wp_r + LIT_AW'(1);
      end
      if (lit_pop_i) begin
        lit_rp_r <= lit_rp_r + LIT_AW'(1);
      end
      lit_cnt_r <= lit_cnt_r + LIT_CNT_W'(push_i.valid) - LIT_CNT_W'(lit_pop_i);
    end
  end

  lirenc_ram #(
    .WIDTH (8),
    .DEPTH (LIT_DEPTH)
  ) u_lit_ram (
    .clk     (clk),
    .wr_en   (push_i.valid),
    .wr_addr (lit_wp_r),
    .wr_data (push_i.data),
    .rd_en   (lit_pop_i),
    .rd_addr (lit_rp_r),
    .rd_data (lit_data_o)
  );

endmodule

@@ design/lirenc_back.sv @@
// Back end: takes chunk commands, sends the header and then reads the
// chunk's literals out of the literal FIFO. Depends on lirenc_pkg.
module lirenc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_empty_i,
  input  lirenc_pkg::chunk_cmd_t cmd_i,
  output logic                   cmd_pop_o,
  output logic                   lit_pop_o,
  input  logic [7:0]             lit_data_i,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_data,
  output logic                   out_last
);
  import lirenc_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_HDR  = 3'b010,
    B_LIT  = 3'b100
  } back_state_t;

  back_state_t      state_r, state_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] rd_left_r, rd_left_nxt;
  logic [CNT_W-1:0] out_left_r, out_left_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;

  logic             slot_free;
  logic             out_load;
  logic [7:0]       out_byte;
  logic             out_byte_last;
  logic             load_lit;
  logic             issue;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    hdr_nxt       = hdr_r;
    last_nxt      = last_r;
    rd_left_nxt   = rd_left_r;
    out_left_nxt  = out_left_r;
    pend_nxt      = pend_r;
    cmd_pop_o     = 1'b0;
    lit_pop_o     = 1'b0;
    out_load      = 1'b0;
    out_byte      = hdr_r;
    out_byte_last = 1'b0;
    load_lit      = 1'b0;
    issue         = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          hdr_nxt   = cmd_i.hdr;
          last_nxt  = cmd_i.last;
          state_nxt = B_HDR;
        end
      end
      B_HDR: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_byte      = hdr_r;
          out_byte_last = last_r && (hdr_r[CNT_W-1:0] == '0);
          rd_left_nxt   = hdr_r[CNT_W-1:0];
          out_left_nxt  = hdr_r[CNT_W-1:0];
          pend_nxt      = 1'b0;
          state_nxt     = (hdr_r[CNT_W-1:0] == '0) ? B_IDLE : B_LIT;
        end
      end
      B_LIT: begin
        // Read data stays in the RAM's output register until it moves on.
        load_lit = pend_r && slot_free;
        issue    = (rd_left_r != '0) && (!pend_r || load_lit);
        if (load_lit) begin
          out_load      = 1'b1;
          out_byte      = lit_data_i;
          out_byte_last = last_r && (out_left_r == CNT_W'(1));
          out_left_nxt  = out_left_r - CNT_W'(1);
          if (out_left_r == CNT_W'(1)) begin
            state_nxt = B_IDLE;
          end
        end
        if (issue) begin
          lit_pop_o   = 1'b1;
          rd_left_nxt = rd_left_r - CNT_W'(1);
        end
        pend_nxt = issue || (pend_r && !load_lit);
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    last_r     <= last_nxt;
    rd_left_r  <= rd_left_nxt;
    out_left_r <= out_left_nxt;
    if (out_load) begin
      out_data_r <= out_byte;
      out_last_r <= out_byte_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule
